// ===== rtl/srg_pkg.sv =====
// Shared types and constants for the step-pulse ramp generator.
package srg_pkg;

  localparam int unsigned RELOAD_DIVIDEND_DEF = 1000000;
  localparam int unsigned COUNTER_MAX_DEF     = 65535;

  localparam int FREQ_W  = 16;
  localparam int RELOAD_W = 16;
  localparam int STEPS_W = 8;
  localparam int IVL_W   = 24;
  localparam int FUNC_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [RELOAD_W-1:0] INIT_RELOAD_RST = 16'd60535;
  localparam logic [STEPS_W-1:0]  ACCEL_STEPS_RST = 8'd50;
  localparam logic [STEPS_W-1:0]  DECEL_STEPS_RST = 8'd10;
  localparam logic [IVL_W-1:0]    RAMP_IVL_RST    = 24'd80000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_TARGET = 2'd1,
    FUNC_DIR    = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_RELOAD = 2'd0,
    CFG_ACCEL_STEPS = 2'd1,
    CFG_DECEL_STEPS = 2'd2,
    CFG_RAMP_IVL    = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_RAMP  = 2'd0,
    OP_APPLY = 2'd1,
    OP_STEP  = 2'd2
  } pend_op_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic finish;
    logic load_out;
  } srg_cmd_t;

  typedef struct packed {
    logic needs_div;
    logic div_done;
  } srg_sts_t;

endpackage

// ===== rtl/step_pulse_ramp_generator.sv =====
// Top level of the step-pulse generator with linear frequency ramp.
//
// Input channel (in_valid/in_ready): func selects a timer tick, a new target
// frequency or a new direction. Every transaction yields one result on the
// output channel (out_valid/out_ready): step and direction levels, frequency
// and reload in effect, a save strobe and a ramp busy flag.
// Configuration (cfg_valid/cfg_ready, always ready): cfg_index picks
// initial_reload, accel_steps, decel_steps or ramp_interval; write only idle.
// A plain tick, a direction change or a target ignored mid-ramp gives its
// result in the cycle after acceptance. A tick that applies a ramp step,
// and an accepted target, run the shared restoring divider one quotient
// bit per cycle. Throughput is one transaction per cycle for plain ticks
// while the receiver is ready; no new transaction is taken while the
// divider runs.
// Reset loads the default registers, the counter and reload with
// initial_reload, and clears frequency, ramp and step and direction levels.
// A stalled receiver holds the result register; one new transaction is
// taken only in the cycle the waiting result leaves.
module step_pulse_ramp_generator import srg_pkg::*; #(
  parameter int unsigned RELOAD_DIVIDEND = RELOAD_DIVIDEND_DEF,
  parameter int unsigned COUNTER_MAX     = COUNTER_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FUNC_W-1:0]     func,
  input  logic [FREQ_W-1:0]     target_freq,
  input  logic                  direction,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  step_out,
  output logic                  dir_out,
  output logic [FREQ_W-1:0]     current_freq,
  output logic [RELOAD_W-1:0]   reload_value,
  output logic                  save_strobe,
  output logic                  busy_res
);

  srg_cmd_t cmd;
  srg_sts_t sts;

  assign cfg_ready = 1'b1;

  srg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  srg_dp #(
    .RELOAD_DIVIDEND (RELOAD_DIVIDEND),
    .COUNTER_MAX     (COUNTER_MAX)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .func         (func),
    .target_freq  (target_freq),
    .direction    (direction),
    .step_out     (step_out),
    .dir_out      (dir_out),
    .current_freq (current_freq),
    .reload_value (reload_value),
    .save_strobe  (save_strobe),
    .busy_res     (busy_res)
  );

endmodule

// ===== rtl/srg_div.sv =====
// Restoring divider, one quotient bit per cycle.
module srg_div import srg_pkg::*; #(
  parameter int QW = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [QW-1:0]     dividend,
  input  logic [FREQ_W-1:0] divisor,
  output logic              done,
  output logic [QW-1:0]     quotient
);

  localparam int CNT_W = $clog2(QW + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [FREQ_W:0]   rem;
  logic [QW-1:0]     quo;
  logic [FREQ_W-1:0] dvs;
  logic [FREQ_W:0]   rem_sh;
  logic              ge;

  assign rem_sh   = {rem[FREQ_W-1:0], quo[QW-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? (rem_sh - {1'b0, dvs}) : rem_sh;
      quo <= {quo[QW-2:0], ge};
    end
  end

endmodule

// ===== rtl/srg_dp.sv =====
// Datapath: configuration, counters, ramp registers, divider and result register.
module srg_dp import srg_pkg::*; #(
  parameter int unsigned RELOAD_DIVIDEND = RELOAD_DIVIDEND_DEF,
  parameter int unsigned COUNTER_MAX     = COUNTER_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  srg_cmd_t              cmd,
  output srg_sts_t              sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [FUNC_W-1:0]     func,
  input  logic [FREQ_W-1:0]     target_freq,
  input  logic                  direction,
  output logic                  step_out,
  output logic                  dir_out,
  output logic [FREQ_W-1:0]     current_freq,
  output logic [RELOAD_W-1:0]   reload_value,
  output logic                  save_strobe,
  output logic                  busy_res
);

  localparam int DIV_W = $clog2(RELOAD_DIVIDEND + 1);
  localparam int QW    = (DIV_W > FREQ_W) ? DIV_W : FREQ_W;
  localparam int CNT_W = $clog2(COUNTER_MAX + 1);
  localparam int TW    = (CNT_W > RELOAD_W) ? CNT_W : RELOAD_W;
  localparam int CMP_W = (QW > CNT_W) ? QW : CNT_W;
  localparam logic [TW-1:0]    CMAX_T = TW'(COUNTER_MAX);
  localparam logic [CMP_W-1:0] CMAX_C = CMP_W'(COUNTER_MAX);
  localparam logic [QW-1:0]    DIVD   = QW'(RELOAD_DIVIDEND);

  logic [RELOAD_W-1:0] initial_reload, initial_reload_next;
  logic [STEPS_W-1:0]  accel_steps, accel_steps_next;
  logic [STEPS_W-1:0]  decel_steps, decel_steps_next;
  logic [IVL_W-1:0]    ramp_interval, ramp_interval_next;
  logic [TW-1:0]       tick_counter, tick_counter_next;
  logic [RELOAD_W-1:0] reload_reg, reload_reg_next;
  logic [FREQ_W-1:0]   freq_now, freq_now_next;
  logic [FREQ_W-1:0]   step_size, step_size_next;
  logic [STEPS_W-1:0]  steps_left, steps_left_next;
  logic                ramp_up, ramp_up_next;
  logic [IVL_W-1:0]    interval_count, interval_count_next;
  logic                step_level, step_level_next;
  logic                dir_level, dir_level_next;
  pend_op_t            pend_op, pend_op_next;
  logic                save_next;

  logic [IVL_W-1:0]    ic_inc;
  logic                ramp_hit;
  logic [QW-1:0]       div_dividend;
  logic [FREQ_W-1:0]   div_divisor;
  logic                div_done;
  logic [QW-1:0]       quotient;
  logic [CMP_W-1:0]    quo_ext;
  logic [CMP_W-1:0]    rel_diff;
  logic [RELOAD_W-1:0] reload_calc;
  logic [STEPS_W-1:0]  n_up, n_dn;

  assign ic_inc   = interval_count + 1'b1;
  assign ramp_hit = (steps_left != '0) && (ic_inc >= ramp_interval);
  assign n_up     = (accel_steps != '0) ? accel_steps : STEPS_W'(1);
  assign n_dn     = (decel_steps != '0) ? decel_steps : STEPS_W'(1);

  assign sts.needs_div = ((func == FUNC_TICK) && ramp_hit) ||
                         ((func == FUNC_TARGET) && (steps_left == '0));
  assign sts.div_done  = div_done;

  assign quo_ext     = CMP_W'(quotient);
  assign rel_diff    = CMAX_C - quo_ext;
  assign reload_calc = ((freq_now == '0) || (quo_ext > CMAX_C)) ? '0 : rel_diff[RELOAD_W-1:0];

  always_comb begin
    initial_reload_next = initial_reload;
    accel_steps_next    = accel_steps;
    decel_steps_next    = decel_steps;
    ramp_interval_next  = ramp_interval;
    tick_counter_next   = tick_counter;
    reload_reg_next     = reload_reg;
    freq_now_next       = freq_now;
    step_size_next      = step_size;
    steps_left_next     = steps_left;
    ramp_up_next        = ramp_up;
    interval_count_next = interval_count;
    step_level_next     = step_level;
    dir_level_next      = dir_level;
    pend_op_next        = pend_op;
    save_next           = 1'b0;
    div_dividend        = DIVD;
    div_divisor         = freq_now;

    if (cfg_we) begin
      case (cfg_index)
        CFG_INIT_RELOAD: begin
          initial_reload_next = cfg_data[RELOAD_W-1:0];
          reload_reg_next     = cfg_data[RELOAD_W-1:0];
          tick_counter_next   = TW'(cfg_data[RELOAD_W-1:0]);
        end
        CFG_ACCEL_STEPS: accel_steps_next   = cfg_data[STEPS_W-1:0];
        CFG_DECEL_STEPS: decel_steps_next   = cfg_data[STEPS_W-1:0];
        CFG_RAMP_IVL:    ramp_interval_next = cfg_data[IVL_W-1:0];
        default: ;
      endcase
    end

    if (cmd.accept) begin
      case (func)
        FUNC_TICK: begin
          if (tick_counter >= CMAX_T) begin
            tick_counter_next = TW'(reload_reg);
            step_level_next   = ~step_level;
          end else begin
            tick_counter_next = tick_counter + 1'b1;
          end
          if (steps_left != '0) begin
            if (ramp_hit) begin
              interval_count_next = '0;
              freq_now_next = ramp_up ? (freq_now + step_size) : (freq_now - step_size);
              pend_op_next  = OP_RAMP;
            end else begin
              interval_count_next = ic_inc;
            end
          end
          div_divisor = freq_now_next;
        end
        FUNC_TARGET: begin
          if (steps_left == '0) begin
            if (target_freq == freq_now) begin
              pend_op_next = OP_APPLY;
            end else begin
              pend_op_next        = OP_STEP;
              interval_count_next = '0;
              if (target_freq > freq_now) begin
                ramp_up_next    = 1'b1;
                steps_left_next = n_up;
                div_dividend    = QW'(target_freq - freq_now);
                div_divisor     = FREQ_W'(n_up);
              end else begin
                ramp_up_next    = 1'b0;
                steps_left_next = n_dn;
                div_dividend    = QW'(freq_now - target_freq);
                div_divisor     = FREQ_W'(n_dn);
              end
            end
          end
        end
        FUNC_DIR: dir_level_next = direction;
        default: ;
      endcase
    end

    if (cmd.finish) begin
      case (pend_op)
        OP_RAMP: begin
          reload_reg_next = reload_calc;
          steps_left_next = steps_left - 1'b1;
          save_next       = (steps_left == STEPS_W'(1));
        end
        OP_APPLY: begin
          reload_reg_next = reload_calc;
          save_next       = 1'b1;
        end
        OP_STEP: step_size_next = quotient[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  srg_div #(.QW(QW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_reload <= INIT_RELOAD_RST;
      accel_steps    <= ACCEL_STEPS_RST;
      decel_steps    <= DECEL_STEPS_RST;
      ramp_interval  <= RAMP_IVL_RST;
      tick_counter   <= TW'(INIT_RELOAD_RST);
      reload_reg     <= INIT_RELOAD_RST;
      freq_now       <= '0;
      step_size      <= '0;
      steps_left     <= '0;
      ramp_up        <= 1'b0;
      interval_count <= '0;
      step_level     <= 1'b0;
      dir_level      <= 1'b0;
      pend_op        <= OP_RAMP;
    end else begin
      initial_reload <= initial_reload_next;
      accel_steps    <= accel_steps_next;
      decel_steps    <= decel_steps_next;
      ramp_interval  <= ramp_interval_next;
      tick_counter   <= tick_counter_next;
      reload_reg     <= reload_reg_next;
      freq_now       <= freq_now_next;
      step_size      <= step_size_next;
      steps_left     <= steps_left_next;
      ramp_up        <= ramp_up_next;
      interval_count <= interval_count_next;
      step_level     <= step_level_next;
      dir_level      <= dir_level_next;
      pend_op        <= pend_op_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      step_out     <= step_level_next;
      dir_out      <= dir_level_next;
      current_freq <= freq_now_next;
      reload_value <= reload_reg_next;
      save_strobe  <= save_next;
      busy_res     <= (steps_left_next != '0);
    end
  end

endmodule

// ===== rtl/srg_ctrl.sv =====
// Controller: handshakes, divide sequencing and result valid.
module srg_ctrl import srg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  srg_sts_t sts,
  output srg_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);

  always_comb begin
    state_next    = state;
    cmd.accept    = in_valid && in_ready;
    cmd.div_start = 1'b0;
    cmd.finish    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd.accept && sts.needs_div) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    cmd.load_out = (cmd.accept && !sts.needs_div) || cmd.finish;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.load_out || (out_valid && !out_ready);
    end
  end

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the step-pulse ramp generator: random traffic, predictor, scoreboard.
module tb;
  import srg_pkg::*;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 40;

  typedef struct packed {
    logic                step;
    logic                dir;
    logic [FREQ_W-1:0]   freq;
    logic [RELOAD_W-1:0] reload;
    logic                save;
    logic                busy;
  } outputs_t;

  class step_ramp_scoreboard;
    logic [RELOAD_W-1:0] init_reload;
    logic [STEPS_W-1:0]  accel_steps;
    logic [STEPS_W-1:0]  decel_steps;
    logic [IVL_W-1:0]    ramp_ivl;
    logic [RELOAD_W-1:0] tick_count;
    logic [RELOAD_W-1:0] reload;
    logic [FREQ_W-1:0]   freq_hz;
    logic [FREQ_W-1:0]   step_hz;
    logic [STEPS_W-1:0]  steps_left;
    logic                ramp_up;
    logic [IVL_W-1:0]    ivl_count;
    logic                step_level;
    logic                dir_level;
    outputs_t            queued_outputs[$];
    int                  mismatches;

    function new();
      init_reload = INIT_RELOAD_RST;
      accel_steps = ACCEL_STEPS_RST;
      decel_steps = DECEL_STEPS_RST;
      ramp_ivl    = RAMP_IVL_RST;
      tick_count  = INIT_RELOAD_RST;
      reload      = INIT_RELOAD_RST;
      freq_hz     = '0;
      step_hz     = '0;
      steps_left  = '0;
      ramp_up     = 1'b0;
      ivl_count   = '0;
      step_level  = 1'b0;
      dir_level   = 1'b0;
      mismatches  = 0;
    endfunction

    function logic [RELOAD_W-1:0] reload_for(logic [FREQ_W-1:0] f);
      int unsigned q;
      if (f == 0) return '0;
      q = RELOAD_DIVIDEND_DEF / f;
      if (q > COUNTER_MAX_DEF) return '0;
      return RELOAD_W'(COUNTER_MAX_DEF - q);
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_INIT_RELOAD: begin
          init_reload = data[RELOAD_W-1:0];
          reload      = init_reload;
          tick_count  = init_reload;
        end
        CFG_ACCEL_STEPS: accel_steps = data[STEPS_W-1:0];
        CFG_DECEL_STEPS: decel_steps = data[STEPS_W-1:0];
        CFG_RAMP_IVL:    ramp_ivl    = data[IVL_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_transaction(func_t op, logic [FREQ_W-1:0] target, logic dir);
      outputs_t           o;
      logic [STEPS_W-1:0] n;
      o.save = 1'b0;
      case (op)
        FUNC_TICK: begin
          if (tick_count >= COUNTER_MAX_DEF) begin
            tick_count = reload;
            step_level = ~step_level;
          end else begin
            tick_count = tick_count + 1'b1;
          end
          if (steps_left != 0) begin
            ivl_count = ivl_count + 1'b1;
            if (ivl_count >= ramp_ivl) begin
              ivl_count  = '0;
              freq_hz    = ramp_up ? freq_hz + step_hz : freq_hz - step_hz;
              reload     = reload_for(freq_hz);
              steps_left = steps_left - 1'b1;
              o.save     = (steps_left == 0);
            end
          end
        end
        FUNC_TARGET: begin
          if (steps_left == 0) begin
            if (target == freq_hz) begin
              reload = reload_for(target);
              o.save = 1'b1;
            end else begin
              if (target > freq_hz) begin
                n       = (accel_steps == 0) ? STEPS_W'(1) : accel_steps;
                step_hz = (target - freq_hz) / n;
                ramp_up = 1'b1;
              end else begin
                n       = (decel_steps == 0) ? STEPS_W'(1) : decel_steps;
                step_hz = (freq_hz - target) / n;
                ramp_up = 1'b0;
              end
              steps_left = n;
              ivl_count  = '0;
            end
          end
        end
        FUNC_DIR: dir_level = dir;
        default: ;
      endcase
      o.step   = step_level;
      o.dir    = dir_level;
      o.freq   = freq_hz;
      o.reload = reload;
      o.busy   = (steps_left != 0);
      queued_outputs.push_back(o);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_outputs(outputs_t got);
      outputs_t want;
      if (queued_outputs.size() == 0) begin
        $error("output transaction with no input transaction outstanding");
        mismatches++;
        return;
      end
      want = queued_outputs.pop_front();
      compare_field("step_out", want.step, got.step);
      compare_field("dir_out", want.dir, got.dir);
      compare_field("current_freq", want.freq, got.freq);
      compare_field("reload_value", want.reload, got.reload);
      compare_field("save_strobe", want.save, got.save);
      compare_field("busy_res", want.busy, got.busy);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = CFG_INIT_RELOAD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  func_t                 func = FUNC_TICK;
  logic [FREQ_W-1:0]     target_freq = '0;
  logic                  direction = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  step_out;
  logic                  dir_out;
  logic [FREQ_W-1:0]     current_freq;
  logic [RELOAD_W-1:0]   reload_value;
  logic                  save_strobe;
  logic                  busy_res;

  step_ramp_scoreboard sb;
  bit                  steady = 1'b0;
  bit                  hold_off_req = 1'b0;
  int                  items_sent = 0;
  int                  phase_end = 0;

  step_pulse_ramp_generator dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .func, .target_freq, .direction,
    .out_valid, .out_ready, .step_out, .dir_out, .current_freq,
    .reload_value, .save_strobe, .busy_res
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin : transaction_monitor
    outputs_t got;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.step   = step_out;
        got.dir    = dir_out;
        got.freq   = current_freq;
        got.reload = reload_value;
        got.save   = save_strobe;
        got.busy   = busy_res;
        sb.check_outputs(got);
      end
      if (in_valid && in_ready) sb.note_transaction(func, target_freq, direction);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (steady || $urandom_range(0, 99) < 80) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("step_pulse_ramp_generator regression: fail");
    $finish;
  end

  task automatic send_item(func_t op, logic [FREQ_W-1:0] tgt, logic dir_bit);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= op;
    target_freq <= tgt;
    direction   <= dir_bit;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.queued_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Fill bits above each register's width with noise; they must be dropped.
  task automatic program_regs(logic [CFG_DATA_W-1:0] init_v, logic [CFG_DATA_W-1:0] accel_v,
                              logic [CFG_DATA_W-1:0] decel_v, logic [CFG_DATA_W-1:0] ivl_v);
    cfg_valid <= 1'b1;
    put_reg(CFG_INIT_RELOAD, {8'($urandom), init_v[15:0]});
    put_reg(CFG_ACCEL_STEPS, {16'($urandom), accel_v[7:0]});
    put_reg(CFG_DECEL_STEPS, {16'($urandom), decel_v[7:0]});
    put_reg(CFG_RAMP_IVL, ivl_v);
    cfg_valid <= 1'b0;
  endtask

  task automatic ramp_sequence();
    logic [FREQ_W-1:0]  tgt;
    logic [FREQ_W-1:0]  now_hz;
    logic [STEPS_W-1:0] n;
    longint             ticks;
    longint             i;
    int                 roll;
    now_hz = sb.freq_hz;
    roll = $urandom_range(0, 9);
    case (roll)
      0:       tgt = now_hz;
      1:       tgt = '0;
      2:       tgt = '1;
      3:       tgt = FREQ_W'($urandom_range(1, 15));
      4, 5:    tgt = now_hz + FREQ_W'($urandom_range(0, 40)) - FREQ_W'(20);
      default: tgt = FREQ_W'($urandom);
    endcase
    send_item(FUNC_TARGET, tgt, 1'($urandom));
    n = (tgt > now_hz) ? sb.accel_steps : sb.decel_steps;
    if (n == 0) n = 1;
    ticks = (tgt == now_hz) ? 0 : longint'(n) * ((sb.ramp_ivl == 0) ? 1 : sb.ramp_ivl);
    ticks += $urandom_range(0, 3);
    if (ticks > 600) ticks = 600;
    for (i = 0; i < ticks && items_sent < phase_end; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) send_item(FUNC_TARGET, FREQ_W'($urandom), 1'($urandom));
      else if (roll < 8) send_item(FUNC_DIR, FREQ_W'($urandom), 1'($urandom));
      else if (roll < 10) send_item(FUNC_NONE, FREQ_W'($urandom), 1'($urandom));
      else send_item(FUNC_TICK, FREQ_W'($urandom), 1'($urandom));
    end
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 6))
      send_item(func_t'($urandom_range(0, 3)), FREQ_W'($urandom), 1'($urandom));
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] init_v, logic [CFG_DATA_W-1:0] accel_v,
                           logic [CFG_DATA_W-1:0] decel_v, logic [CFG_DATA_W-1:0] ivl_v,
                           int quota, bit quiet);
    drain();
    program_regs(init_v, accel_v, decel_v, ivl_v);
    steady = quiet;
    if (quiet) hold_off_req = 1'b1;
    phase_end = items_sent + quota;
    while (items_sent < phase_end) begin
      if ($urandom_range(0, 49) == 0) drain();
      if ($urandom_range(0, 3) != 0) ramp_sequence();
      else noise_burst();
    end
    steady = 1'b0;
  endtask

  initial begin : stimulus
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default registers
    send_item(FUNC_TICK, '1, 1'b1);
    send_item(FUNC_TICK, '0, 1'b0);
    send_item(FUNC_NONE, '1, 1'b1);
    send_item(FUNC_DIR, '0, 1'b1);
    send_item(FUNC_DIR, '1, 1'b0);
    send_item(FUNC_TARGET, '0, 1'b1);
    send_item(FUNC_TICK, '0, 1'b0);
    send_item(FUNC_DIR, '0, 1'b1);

    // zero accel steps, one decel step and zero interval, counter at its top
    drain();
    program_regs(24'h00FFFF, 24'h000000, 24'h000001, 24'h000000);
    send_item(FUNC_TICK, '0, 1'b0);
    send_item(FUNC_TARGET, '1, 1'b0);
    send_item(FUNC_TARGET, FREQ_W'(20), 1'b1);
    send_item(FUNC_DIR, '0, 1'b0);
    send_item(FUNC_TICK, '0, 1'b1);
    send_item(FUNC_TARGET, '1, 1'b0);
    send_item(FUNC_TARGET, '0, 1'b0);
    send_item(FUNC_TICK, '0, 1'b0);
    send_item(FUNC_TARGET, FREQ_W'(15), 1'b0);
    send_item(FUNC_TICK, '0, 1'b0);
    send_item(FUNC_TARGET, FREQ_W'(16), 1'b0);
    send_item(FUNC_TICK, '0, 1'b0);
    send_item(FUNC_NONE, '0, 1'b1);

    run_phase(CFG_DATA_W'($urandom), 4, 3, 2, 200, 1'b0);
    run_phase(24'h000000, 24'h0000FF, 24'h0000FF, 24'h000001, 300, 1'b0);
    run_phase(CFG_DATA_W'($urandom), 1, 1, 24'hFFFFFF, 30, 1'b0);
    run_phase(24'h00FFFF, CFG_DATA_W'($urandom_range(1, 8)), CFG_DATA_W'($urandom_range(1, 8)),
              3, 250, 1'b0);
    run_phase(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(0, 10)),
              CFG_DATA_W'($urandom_range(0, 10)), CFG_DATA_W'($urandom_range(0, 6)),
              250, 1'b1);
    run_phase(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(1, 20)),
              CFG_DATA_W'($urandom_range(1, 20)), CFG_DATA_W'($urandom_range(1, 4)),
              250, 1'b0);
    run_phase(CFG_DATA_W'($urandom), 2, 5, 0, 150, 1'b0);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.queued_outputs.size() == 0) begin
      $display("step_pulse_ramp_generator regression: pass");
    end else begin
      $display("step_pulse_ramp_generator regression: fail");
    end
    $finish;
  end

endmodule
